FILE: src/falc_pkg.sv
// ----------------------------------------------------------------------------
// falc_pkg: shared types and constants of the fire alarm level controller
// Holds the register file layout, the per-tick item and state records, the
// cadence timing and the reset values of configuration and state.
// ----------------------------------------------------------------------------
package falc_pkg;

	localparam int unsigned TempW   = 11;
	localparam int unsigned GasW    = 10;
	localparam int unsigned CountW  = 10;
	localparam int unsigned SinceW  = 8;
	localparam int unsigned AddrW   = 5;
	localparam int unsigned DataW   = 32;
	localparam int unsigned InDataW = 24;
	localparam int unsigned OutDataW = 8;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_TEMP_SAFE   = 3'd0;
	localparam logic [2:0] REG_TEMP_WARN   = 3'd1;
	localparam logic [2:0] REG_GAS_NORMAL  = 3'd2;
	localparam logic [2:0] REG_GAS_WARN    = 3'd3;
	localparam logic [2:0] REG_GAS_DANGER  = 3'd4;
	localparam logic [2:0] REG_TEMP_CHANGE = 3'd5;
	localparam logic [2:0] REG_GAS_CHANGE  = 3'd6;
	localparam logic [2:0] REG_PANIC_DEB   = 3'd7;

	typedef enum logic [1:0] {
		MODE_NONE   = 2'd0,
		MODE_WARN   = 2'd1,
		MODE_DANGER = 2'd2
	} mode_t;

	// lamp bit positions
	localparam int unsigned LAMP_GREEN  = 0;
	localparam int unsigned LAMP_YELLOW = 1;
	localparam int unsigned LAMP_RED    = 2;
	localparam logic [2:0] LampsGreen  = 3'b001;
	localparam logic [2:0] LampsYellow = 3'b010;
	localparam logic [2:0] LampsRed    = 3'b100;
	localparam logic [2:0] LampsAll    = 3'b111;

	localparam logic [CountW-1:0] WarnOnTicks    = 10'd400;
	localparam logic [CountW-1:0] WarnOffTicks   = 10'd600;
	localparam logic [CountW-1:0] DangerOnTicks  = 10'd150;
	localparam logic [CountW-1:0] DangerOffTicks = 10'd150;
	localparam logic [CountW-1:0] CountMax       = 10'd1023;
	localparam logic [SinceW-1:0] SinceMax       = 8'd255;
	localparam logic signed [TempW-1:0] DangerTemp = 11'sd420;

	typedef struct packed {
		logic signed [TempW-1:0] temp_safe_limit;
		logic signed [TempW-1:0] temp_warn_limit;
		logic [GasW-1:0]         gas_normal_limit;
		logic [GasW-1:0]         gas_warn_limit;
		logic [GasW-1:0]         gas_danger_limit;
		logic [7:0]              temp_change_min;
		logic [GasW-1:0]         gas_change_min;
		logic [SinceW-1:0]       panic_debounce_ticks;
	} cfg_t;

	localparam cfg_t CfgReset = '{
		temp_safe_limit:      11'sd350,
		temp_warn_limit:      11'sd380,
		gas_normal_limit:     10'd300,
		gas_warn_limit:       10'd500,
		gas_danger_limit:     10'd700,
		temp_change_min:      8'd2,
		gas_change_min:       10'd10,
		panic_debounce_ticks: 8'd50
	};

	typedef struct packed {
		logic                    panic_event;
		logic                    sample_valid;
		logic signed [TempW-1:0] temperature;
		logic [GasW-1:0]         gas_level;
		logic                    reset_pressed;
	} item_t;

	typedef struct packed {
		logic [2:0]              lamp_bits;
		mode_t                   alarm_mode;
		logic                    sounding;
		logic [CountW-1:0]       cadence_count;
		logic signed [TempW-1:0] last_temperature;
		logic [GasW-1:0]         last_gas;
		logic [SinceW-1:0]       since_panic;
	} state_t;

	localparam state_t StateReset = '{
		lamp_bits:        3'b000,
		alarm_mode:       MODE_NONE,
		sounding:         1'b0,
		cadence_count:    '0,
		last_temperature: '0,
		last_gas:         '0,
		since_panic:      '0
	};

endpackage

FILE: src/fire_alarm_level_controller.sv
// ----------------------------------------------------------------------------
// fire_alarm_level_controller: lamp and buzzer control of a fire alarm
// One stream item per millisecond tick in, one lamp/buzzer status out.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream s_axis carries one tick per transfer: a panic press edge,
//    an optional temperature/gas sample (tuser marks it valid) and the
//    reset button level. Every accepted tick yields exactly one transfer on
//    m_axis: the three lamp levels, buzzer sounding, tone select and the
//    alarm level (none, warning, danger).
//  - Thresholds live in eight APB registers at byte addresses 0x00..0x1C;
//    write them only while the stream is idle. pready is tied high.
//  - Path: input register holds the tick, output register holds its status.
//  - Throughput: one tick per clock cycle unless m_axis is held off. The
//    whole tick fits in one pass of logic between the input and output
//    registers; the only loop is the state register fed back from that logic.
//  - Stall: when m_axis is held off, the output register keeps its status
//    and the input register holds one more tick; s_axis_tready drops once
//    both are full and rises in the cycle the receiver takes the status.
//  - Reset (arst_n low): lamps dark, alarm silent, counters and the last
//    sample cleared, registers back to their default thresholds, both
//    stream registers emptied.
// ----------------------------------------------------------------------------
module fire_alarm_level_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	// APB configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [falc_pkg::AddrW-1:0]        paddr,
	input  logic [falc_pkg::DataW-1:0]        pwdata,
	output logic [falc_pkg::DataW-1:0]        prdata,
	output logic                              pready,
	// tick input
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [0] panic_event, [11:1] temperature, [21:12] gas_level,
	// [22] reset_pressed, [23] zero
	input  logic [falc_pkg::InDataW-1:0]      s_axis_tdata,
	// [0] sample_valid
	input  logic                              s_axis_tuser,
	// status output
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [0] led_green, [1] led_yellow, [2] led_red, [3] buzzer_on,
	// [4] tone_high, [6:5] alarm_level, [7] zero
	output logic [falc_pkg::OutDataW-1:0]     m_axis_tdata
);

	falc_pkg::cfg_t   cfg;
	falc_pkg::item_t  item_s1;
	logic             valid_s1;
	falc_pkg::state_t state_q;
	falc_pkg::state_t state_nxt;
	logic             out_valid_q;
	logic [falc_pkg::OutDataW-1:0] out_data_q;
	logic             s_xfer;
	logic             adv;

	falc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	falc_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.cfg  (cfg),
		.nxt  (state_nxt)
	);

	// advance the held tick whenever the output register is free or drains
	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign s_xfer        = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// control: input and output occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_xfer) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// alarm state: advance once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= falc_pkg::StateReset;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// payload: capture the tick, then the status it leaves behind
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			item_s1.panic_event   <= s_axis_tdata[0];
			item_s1.temperature   <= s_axis_tdata[11:1];
			item_s1.gas_level     <= s_axis_tdata[21:12];
			item_s1.reset_pressed <= s_axis_tdata[22];
			item_s1.sample_valid  <= s_axis_tuser;
		end
		if (adv) begin
			out_data_q <= {1'b0,
				state_nxt.alarm_mode,
				(state_nxt.alarm_mode == falc_pkg::MODE_DANGER),
				state_nxt.sounding,
				state_nxt.lamp_bits[falc_pkg::LAMP_RED],
				state_nxt.lamp_bits[falc_pkg::LAMP_YELLOW],
				state_nxt.lamp_bits[falc_pkg::LAMP_GREEN]};
		end
	end

	// a held tick always leaves a status in the output register
	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("tick advanced without loading the status register");

	// the tone select follows the danger level
	a_tone_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q[4] == (out_data_q[6:5] == falc_pkg::MODE_DANGER)))
		else $error("tone select disagrees with alarm level");

	// the buzzer never sounds with no alarm
	a_silent_none: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.alarm_mode == falc_pkg::MODE_NONE) |-> !state_q.sounding)
		else $error("buzzer sounding while no alarm is active");

	// lamps show one color, all colors, or none
	a_lamp_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(state_q.lamp_bits) || (state_q.lamp_bits == falc_pkg::LampsAll))
		else $error("illegal lamp pattern");

	// an accepted panic press restarts the debounce window
	a_panic_window: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.panic_event
			&& (state_nxt.alarm_mode == falc_pkg::MODE_DANGER)
			&& (state_nxt.since_panic == '0))
		|=> (state_q.since_panic == '0))
		else $error("debounce counter not restarted by panic press");

	// a full input register takes no new tick until it can hand its own tick on
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |-> !s_axis_tready)
		else $error("input register overrun");

endmodule

FILE: src/falc_regs.sv
// ----------------------------------------------------------------------------
// falc_regs: configuration register file
// Eight thresholds behind a simple APB port, written in the access phase,
// read back zero-extended.
// ----------------------------------------------------------------------------
module falc_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [falc_pkg::AddrW-1:0]       paddr,
	input  logic [falc_pkg::DataW-1:0]       pwdata,
	output logic [falc_pkg::DataW-1:0]       prdata,
	output logic                             pready,
	output falc_pkg::cfg_t                   cfg
);

	falc_pkg::cfg_t cfg_q;
	logic [2:0]     reg_idx;
	logic           wr_en;

	assign reg_idx = paddr[falc_pkg::AddrW-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= falc_pkg::CfgReset;
		end else if (wr_en) begin
			unique case (reg_idx)
				falc_pkg::REG_TEMP_SAFE:   cfg_q.temp_safe_limit      <= pwdata[10:0];
				falc_pkg::REG_TEMP_WARN:   cfg_q.temp_warn_limit      <= pwdata[10:0];
				falc_pkg::REG_GAS_NORMAL:  cfg_q.gas_normal_limit     <= pwdata[9:0];
				falc_pkg::REG_GAS_WARN:    cfg_q.gas_warn_limit       <= pwdata[9:0];
				falc_pkg::REG_GAS_DANGER:  cfg_q.gas_danger_limit     <= pwdata[9:0];
				falc_pkg::REG_TEMP_CHANGE: cfg_q.temp_change_min      <= pwdata[7:0];
				falc_pkg::REG_GAS_CHANGE:  cfg_q.gas_change_min       <= pwdata[9:0];
				falc_pkg::REG_PANIC_DEB:   cfg_q.panic_debounce_ticks <= pwdata[7:0];
				default:                   cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			falc_pkg::REG_TEMP_SAFE:   prdata = {21'd0, cfg_q.temp_safe_limit};
			falc_pkg::REG_TEMP_WARN:   prdata = {21'd0, cfg_q.temp_warn_limit};
			falc_pkg::REG_GAS_NORMAL:  prdata = {22'd0, cfg_q.gas_normal_limit};
			falc_pkg::REG_GAS_WARN:    prdata = {22'd0, cfg_q.gas_warn_limit};
			falc_pkg::REG_GAS_DANGER:  prdata = {22'd0, cfg_q.gas_danger_limit};
			falc_pkg::REG_TEMP_CHANGE: prdata = {24'd0, cfg_q.temp_change_min};
			falc_pkg::REG_GAS_CHANGE:  prdata = {22'd0, cfg_q.gas_change_min};
			falc_pkg::REG_PANIC_DEB:   prdata = {24'd0, cfg_q.panic_debounce_ticks};
			default:                   prdata = '0;
		endcase
	end

endmodule

FILE: src/falc_step.sv
// ----------------------------------------------------------------------------
// falc_step: next-state logic for one millisecond tick
// Panic press, then buzzer cadence, then sample evaluation, in that order.
// ----------------------------------------------------------------------------
module falc_step (
	input  falc_pkg::state_t cur,
	input  falc_pkg::item_t  item,
	input  falc_pkg::cfg_t   cfg,
	output falc_pkg::state_t nxt
);

	logic signed [falc_pkg::TempW:0] dt_raw;
	logic [falc_pkg::TempW:0]        dt_abs;
	logic signed [falc_pkg::GasW:0]  dg_raw;
	logic [falc_pkg::GasW:0]         dg_abs;
	logic [falc_pkg::CountW-1:0]     interval;
	logic                            changed;
	logic                            safe_hit;
	logic                            warn_hit;
	logic                            danger_hit;

	// distance from the last evaluated sample
	assign dt_raw = {item.temperature[falc_pkg::TempW-1], item.temperature}
		- {cur.last_temperature[falc_pkg::TempW-1], cur.last_temperature};
	assign dt_abs = dt_raw[falc_pkg::TempW] ? (-dt_raw) : dt_raw;
	assign dg_raw = {1'b0, item.gas_level} - {1'b0, cur.last_gas};
	assign dg_abs = dg_raw[falc_pkg::GasW] ? (-dg_raw) : dg_raw;

	assign changed = (dt_abs >= {4'd0, cfg.temp_change_min})
		|| (dg_abs >= {1'b0, cfg.gas_change_min});

	assign safe_hit = (item.temperature <= cfg.temp_safe_limit)
		&& (item.gas_level <= cfg.gas_normal_limit);
	assign warn_hit = ((item.temperature > cfg.temp_safe_limit)
		&& (item.temperature <= cfg.temp_warn_limit))
		|| ((item.gas_level >= cfg.gas_warn_limit)
		&& (item.gas_level <= cfg.gas_danger_limit));
	assign danger_hit = (item.temperature > cfg.temp_warn_limit)
		|| (item.temperature >= falc_pkg::DangerTemp)
		|| (item.gas_level >= cfg.gas_danger_limit);

	always_comb begin
		nxt = cur;

		// saturating tick counters
		if (cur.since_panic != falc_pkg::SinceMax) begin
			nxt.since_panic = cur.since_panic + 1'b1;
		end
		if (cur.cadence_count != falc_pkg::CountMax) begin
			nxt.cadence_count = cur.cadence_count + 1'b1;
		end

		if (item.panic_event && (nxt.since_panic >= cfg.panic_debounce_ticks)) begin
			nxt.since_panic   = '0;
			nxt.lamp_bits     = falc_pkg::LampsRed;
			nxt.alarm_mode    = falc_pkg::MODE_DANGER;
			nxt.cadence_count = '0;
			nxt.sounding      = 1'b0;
		end

		unique case (nxt.alarm_mode)
			falc_pkg::MODE_WARN: begin
				interval = nxt.sounding ? falc_pkg::WarnOnTicks : falc_pkg::WarnOffTicks;
			end
			falc_pkg::MODE_DANGER: begin
				interval = nxt.sounding ? falc_pkg::DangerOnTicks : falc_pkg::DangerOffTicks;
			end
			default: begin
				interval = falc_pkg::CountMax;
			end
		endcase
		if ((nxt.alarm_mode != falc_pkg::MODE_NONE) && (nxt.cadence_count >= interval)) begin
			nxt.cadence_count = '0;
			nxt.sounding      = !nxt.sounding;
		end

		if (item.sample_valid) begin
			if (item.reset_pressed) begin
				nxt.lamp_bits  = falc_pkg::LampsAll;
				nxt.alarm_mode = falc_pkg::MODE_NONE;
				nxt.sounding   = 1'b0;
			end else if (changed) begin
				priority if (safe_hit) begin
					nxt.alarm_mode       = falc_pkg::MODE_NONE;
					nxt.sounding         = 1'b0;
					nxt.lamp_bits        = falc_pkg::LampsGreen;
					nxt.last_temperature = item.temperature;
					nxt.last_gas         = item.gas_level;
				end else if (warn_hit) begin
					nxt.alarm_mode       = falc_pkg::MODE_WARN;
					nxt.cadence_count    = '0;
					nxt.sounding         = 1'b0;
					nxt.lamp_bits        = falc_pkg::LampsYellow;
					nxt.last_temperature = item.temperature;
					nxt.last_gas         = item.gas_level;
				end else if (danger_hit) begin
					nxt.alarm_mode       = falc_pkg::MODE_DANGER;
					nxt.cadence_count    = '0;
					nxt.sounding         = 1'b0;
					nxt.lamp_bits        = falc_pkg::LampsRed;
					nxt.last_temperature = item.temperature;
					nxt.last_gas         = item.gas_level;
				end else begin
					// no band matched: keep everything, including the last sample
					nxt.last_gas = cur.last_gas;
				end
			end
		end
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench of the fire alarm level controller
// Streams millisecond ticks into the block, loads threshold sets over APB
// between phases and checks every status transfer, field by field, against
// a scoreboard that tracks lamps, alarm mode, buzzer cadence and debounce.
// ----------------------------------------------------------------------------
module tb;
	import falc_pkg::*;

	localparam int ClkHalf       = 6;
	localparam int ResetCycles   = 6;
	localparam int StallLimit    = 3000;
	localparam int DrainCycles   = 8;
	localparam int HoldOffCycles = 80;
	localparam int LongQuota     = 1100;
	localparam int PhaseQuota    = 140;
	localparam int RandomPhases  = 5;
	localparam int TempLo        = -420;
	localparam int TempHi        = 780;
	localparam int GasTop        = 1023;
	localparam int ReportMax     = 10;

	// status transfer, lowest bit first: green, yellow, red, buzzer, tone,
	// alarm level (2), pad
	typedef struct packed {
		logic       pad;
		logic [1:0] level;
		logic       tone;
		logic       buzzer;
		logic       red;
		logic       yellow;
		logic       green;
	} status_t;

	typedef enum int {
		EP_NOISE,
		EP_WARN,
		EP_DANGER,
		EP_SAFE,
		EP_RESET,
		EP_PANIC
	} episode_t;

	// Tracks the controller state tick by tick and holds the statuses due.
	class alarm_board;
		cfg_t              cfg;
		logic [2:0]        lamps;
		mode_t             mode;
		logic              sounding;
		logic [CountW-1:0] cadence;
		int                last_temp;
		int                last_gas;
		logic [SinceW-1:0] since_press;
		status_t           status_due[$];
		int                mismatches;

		function new();
			cfg         = CfgReset;
			lamps       = 3'b000;
			mode        = MODE_NONE;
			sounding    = 1'b0;
			cadence     = '0;
			last_temp   = 0;
			last_gas    = 0;
			since_press = '0;
			mismatches  = 0;
		endfunction

		function void begin_alarm(mode_t m);
			mode     = m;
			cadence  = '0;
			sounding = 1'b0;
		endfunction

		function void judge_sample(item_t it);
			int t, g, dt, dg, safe_t, warn_t, gn, gw, gd, tmin, gmin;
			t      = int'(it.temperature);
			g      = int'(it.gas_level);
			safe_t = int'(cfg.temp_safe_limit);
			warn_t = int'(cfg.temp_warn_limit);
			gn     = int'(cfg.gas_normal_limit);
			gw     = int'(cfg.gas_warn_limit);
			gd     = int'(cfg.gas_danger_limit);
			tmin   = int'(cfg.temp_change_min);
			gmin   = int'(cfg.gas_change_min);
			dt     = t - last_temp;
			dg     = g - last_gas;
			if (dt < 0) dt = -dt;
			if (dg < 0) dg = -dg;
			if (it.reset_pressed) begin
				// reset lights everything and silences, sample not kept
				lamps    = LampsAll;
				mode     = MODE_NONE;
				sounding = 1'b0;
				return;
			end
			if (!(dt >= tmin || dg >= gmin)) return;
			if (t <= safe_t && g <= gn) begin
				mode     = MODE_NONE;
				sounding = 1'b0;
				lamps    = LampsGreen;
			end else if ((t > safe_t && t <= warn_t) || (g >= gw && g <= gd)) begin
				begin_alarm(MODE_WARN);
				lamps = LampsYellow;
			end else if (t > warn_t || t >= int'(DangerTemp) || g >= gd) begin
				begin_alarm(MODE_DANGER);
				lamps = LampsRed;
			end else begin
				// no band: keep the older sample as the reference
				return;
			end
			last_temp = t;
			last_gas  = g;
		endfunction

		function void take_tick(item_t it);
			logic [CountW-1:0] span;
			status_t want;
			if (since_press != SinceMax) since_press++;
			if (cadence != CountMax) cadence++;
			if (it.panic_event && since_press >= cfg.panic_debounce_ticks) begin
				since_press = '0;
				lamps       = LampsRed;
				begin_alarm(MODE_DANGER);
			end
			if (mode != MODE_NONE) begin
				if (mode == MODE_WARN) span = sounding ? WarnOnTicks : WarnOffTicks;
				else span = sounding ? DangerOnTicks : DangerOffTicks;
				if (cadence >= span) begin
					cadence  = '0;
					sounding = ~sounding;
				end
			end
			if (it.sample_valid) judge_sample(it);
			want.pad    = 1'b0;
			want.level  = mode;
			want.tone   = (mode == MODE_DANGER);
			want.buzzer = sounding;
			want.red    = lamps[LAMP_RED];
			want.yellow = lamps[LAMP_YELLOW];
			want.green  = lamps[LAMP_GREEN];
			status_due.push_back(want);
		endfunction

		function void match_status(logic [OutDataW-1:0] raw);
			status_t got, want;
			got = raw;
			if (status_due.size() == 0) begin
				mismatches++;
				if (mismatches <= ReportMax)
					$display("unexpected status transfer %b at %0t", raw, $realtime);
				return;
			end
			want = status_due.pop_front();
			if (got.green !== want.green || got.yellow !== want.yellow ||
					got.red !== want.red || got.buzzer !== want.buzzer ||
					got.tone !== want.tone || got.level !== want.level ||
					got.pad !== want.pad) begin
				mismatches++;
				if (mismatches <= ReportMax)
					$display("status mismatch at %0t: expected %b, got %b",
						$realtime, want, got);
			end
		endfunction

		function int pending();
			return status_due.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [AddrW-1:0]    paddr;
	logic [DataW-1:0]    pwdata;
	logic [DataW-1:0]    prdata;
	logic                pready;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	// [0] panic_event, [11:1] temperature, [21:12] gas_level,
	// [22] reset_pressed, [23] zero
	logic [InDataW-1:0]  s_axis_tdata;
	// [0] sample_valid
	logic                s_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	// [0] led_green, [1] led_yellow, [2] led_red, [3] buzzer_on,
	// [4] tone_high, [6:5] alarm_level, [7] zero
	logic [OutDataW-1:0] m_axis_tdata;

	alarm_board board;
	int         src_idle_pct;
	int         snk_stall_pct;
	bit         sink_hold_req;

	fire_alarm_level_controller dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #(ClkHalf) clk = ~clk;
	end

	function automatic int clamp(int v, int lo, int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Half of the temperatures land within a few tenths of a decision point.
	function automatic int pick_temp();
		int anchor;
		case ($urandom_range(0, 5))
			0: anchor = int'(board.cfg.temp_safe_limit);
			1: anchor = int'(board.cfg.temp_warn_limit);
			2: anchor = int'(DangerTemp);
			default: return int'($urandom_range(0, TempHi - TempLo)) + TempLo;
		endcase
		return clamp(anchor + int'($urandom_range(0, 6)) - 3, TempLo, TempHi);
	endfunction

	function automatic int pick_gas();
		int anchor;
		case ($urandom_range(0, 5))
			0: anchor = int'(board.cfg.gas_normal_limit);
			1: anchor = int'(board.cfg.gas_warn_limit);
			2: anchor = int'(board.cfg.gas_danger_limit);
			default: return int'($urandom_range(0, GasTop));
		endcase
		return clamp(anchor + int'($urandom_range(0, 6)) - 3, 0, GasTop);
	endfunction

	function automatic item_t random_tick();
		item_t it;
		it.panic_event   = ($urandom_range(0, 5) == 0);
		it.sample_valid  = ($urandom_range(0, 3) != 0);
		it.temperature   = TempW'(pick_temp());
		it.gas_level     = GasW'(pick_gas());
		it.reset_pressed = ($urandom_range(0, 7) == 0);
		return it;
	endfunction

	// A tick that lets the cadence run: no press, no sample, random payload.
	function automatic item_t quiet_tick();
		item_t it;
		it               = random_tick();
		it.panic_event   = 1'b0;
		it.sample_valid  = 1'b0;
		it.reset_pressed = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// Build a sample aimed at one band of the current thresholds.
	function automatic item_t trigger_tick(episode_t kind);
		item_t it;
		int lo, hi, safe_t, warn_t, gn, gw, gd;
		it               = random_tick();
		it.panic_event   = 1'b0;
		it.sample_valid  = 1'b1;
		it.reset_pressed = 1'b0;
		safe_t = int'(board.cfg.temp_safe_limit);
		warn_t = int'(board.cfg.temp_warn_limit);
		gn     = int'(board.cfg.gas_normal_limit);
		gw     = int'(board.cfg.gas_warn_limit);
		gd     = int'(board.cfg.gas_danger_limit);
		case (kind)
			EP_WARN: begin
				lo = clamp(safe_t + 1, TempLo, TempHi);
				hi = clamp(warn_t, TempLo, TempHi);
				if (lo <= hi && $urandom_range(0, 1))
					it.temperature = TempW'(lo + int'($urandom_range(0, hi - lo)));
				else if (gw <= gd)
					it.gas_level = GasW'(gw + int'($urandom_range(0, gd - gw)));
			end
			EP_DANGER: begin
				if ($urandom_range(0, 1)) begin
					it.panic_event  = 1'b1;
					it.sample_valid = 1'b0;
				end else begin
					it.temperature = TempW'(TempHi - int'($urandom_range(0, 40)));
					it.gas_level   = GasW'(gd + int'($urandom_range(0, GasTop - gd)));
				end
			end
			EP_SAFE: begin
				hi = clamp(safe_t, TempLo, TempHi);
				if (safe_t >= TempLo)
					it.temperature = TempW'(TempLo + int'($urandom_range(0, hi - TempLo)));
				it.gas_level = GasW'($urandom_range(0, gn));
			end
			EP_RESET: it.reset_pressed = 1'b1;
			default: ;
		endcase
		return it;
	endfunction

	function automatic cfg_t ordered_limits();
		cfg_t c;
		int s, gn, gw;
		s  = int'($urandom_range(0, 1100)) - 400;
		gn = int'($urandom_range(0, 700));
		gw = clamp(gn + int'($urandom_range(0, 200)), 0, GasTop);
		c.temp_safe_limit      = TempW'(s);
		c.temp_warn_limit      = TempW'(clamp(s + int'($urandom_range(0, 120)), -400, 800));
		c.gas_normal_limit     = GasW'(gn);
		c.gas_warn_limit       = GasW'(gw);
		c.gas_danger_limit     = GasW'(clamp(gw + int'($urandom_range(0, 300)), 0, GasTop));
		c.temp_change_min      = 8'($urandom_range(0, 12));
		c.gas_change_min       = GasW'($urandom_range(0, 30));
		c.panic_debounce_ticks = SinceW'($urandom_range(0, 80));
		return c;
	endfunction

	// Limits in any order; temperatures from -400 to 800, the rest across their whole range.
	function automatic cfg_t spread_limits();
		cfg_t c;
		c.temp_safe_limit      = TempW'(int'($urandom_range(0, 1200)) - 400);
		c.temp_warn_limit      = TempW'(int'($urandom_range(0, 1200)) - 400);
		c.gas_normal_limit     = GasW'($urandom_range(0, GasTop));
		c.gas_warn_limit       = GasW'($urandom_range(0, GasTop));
		c.gas_danger_limit     = GasW'($urandom_range(0, GasTop));
		c.temp_change_min      = 8'($urandom_range(0, 255));
		c.gas_change_min       = GasW'($urandom_range(0, GasTop));
		c.panic_debounce_ticks = SinceW'($urandom_range(0, 255));
		return c;
	endfunction

	// Pick how often each side idles for the next stretch of ticks.
	task automatic pick_idling();
		case ($urandom_range(0, 4))
			0, 1: begin
				src_idle_pct  = 0;
				snk_stall_pct = 0;
			end
			2: begin
				src_idle_pct  = 75;
				snk_stall_pct = 0;
			end
			3: begin
				src_idle_pct  = 0;
				snk_stall_pct = 75;
			end
			default: begin
				src_idle_pct  = 17;
				snk_stall_pct = 17;
			end
		endcase
	endtask

	// Offer one tick and hold it until the transfer completes. tvalid is only
	// lowered inside idle cycles, so back-to-back ticks keep it high.
	task automatic send_tick(input item_t it);
		while (int'($urandom_range(0, 99)) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, it.reset_pressed, it.gas_level, it.temperature,
			it.panic_event};
		s_axis_tuser  <= it.sample_valid;
		do @(posedge clk); while (!s_axis_tready);
		board.take_tick(it);
	endtask

	task automatic send_fields(input bit panic, input bit valid, input int temp,
			input int gas, input bit rst);
		item_t it;
		it.panic_event   = panic;
		it.sample_valid  = valid;
		it.temperature   = TempW'(temp);
		it.gas_level     = GasW'(gas);
		it.reset_pressed = rst;
		send_tick(it);
	endtask

	// Stop offering and wait until every status due has been taken.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	// One APB write: setup cycle, then access until pready. psel stays high
	// so that the next write can follow without a gap.
	task automatic apb_write(input logic [2:0] idx, input logic [DataW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= AddrW'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic load_limits(input cfg_t lim);
		apb_write(REG_TEMP_SAFE,   DataW'($signed(lim.temp_safe_limit)));
		apb_write(REG_TEMP_WARN,   DataW'($signed(lim.temp_warn_limit)));
		apb_write(REG_GAS_NORMAL,  DataW'(lim.gas_normal_limit));
		apb_write(REG_GAS_WARN,    DataW'(lim.gas_warn_limit));
		apb_write(REG_GAS_DANGER,  DataW'(lim.gas_danger_limit));
		apb_write(REG_TEMP_CHANGE, DataW'(lim.temp_change_min));
		apb_write(REG_GAS_CHANGE,  DataW'(lim.gas_change_min));
		apb_write(REG_PANIC_DEB,   DataW'(lim.panic_debounce_ticks));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		board.cfg = lim;
	endtask

	// Random ticks as episodes: mostly a sample that starts an alarm, clears
	// it or holds reset, followed by a quiet run so the cadence toggles; the
	// rest is unshaped noise and runs of button presses.
	task automatic run_phase(input int quota, input bit long_warn);
		int sent, n;
		episode_t kind;
		item_t it;
		sent = 0;
		while (sent < quota) begin
			pick_idling();
			kind = episode_t'($urandom_range(0, int'(EP_PANIC)));
			// open with a warning long enough for a full off/on cadence
			if (long_warn && sent == 0) kind = EP_WARN;
			case (kind)
				EP_NOISE: n = $urandom_range(4, 16);
				EP_WARN: begin
					if (long_warn && sent == 0) n = $urandom_range(1010, 1090);
					else n = $urandom_range(10, 120);
				end
				EP_DANGER: begin
					if ($urandom_range(0, 3) == 0) n = $urandom_range(160, 320);
					else n = $urandom_range(10, 80);
				end
				EP_SAFE: n = $urandom_range(5, 40);
				EP_RESET: n = $urandom_range(1, 8);
				default: n = $urandom_range(4, 30);
			endcase
			if (kind != EP_NOISE && kind != EP_PANIC) begin
				send_tick(trigger_tick(kind));
				sent++;
			end
			repeat (n) begin
				// stop at the phase quota
				if (sent >= quota) break;
				case (kind)
					EP_NOISE: it = random_tick();
					EP_PANIC: begin
						it             = quiet_tick();
						it.panic_event = 1'($urandom_range(0, 1));
					end
					default: it = quiet_tick();
				endcase
				send_tick(it);
				sent++;
			end
		end
	endtask

	// Receiver: check each status transfer, then decide the next tready.
	// A requested hold-off keeps tready low for a long stretch so the block
	// fills up and stalls its input.
	initial begin
		int hold_left;
		hold_left = 0;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) board.match_status(m_axis_tdata);
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				hold_left     = HoldOffCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= (int'($urandom_range(0, 99)) >= snk_stall_pct);
			end
		end
	end

	// Watchdog: end the run when nothing moves on any port for too long.
	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < StallLimit) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		cfg_t lim;
		board         = new();
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		sink_hold_req = 1'b0;
		arst_n        <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= 1'b0;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed ticks on the reset thresholds.
		send_fields(1'b0, 1'b0, 0, 0, 1'b0);      // idle tick, nothing lit
		send_fields(1'b1, 1'b0, 0, 0, 1'b0);      // press inside debounce: ignored
		send_fields(1'b0, 1'b1, 0, 0, 1'b0);      // sample unchanged: not judged
		send_fields(1'b0, 1'b1, TempLo, 0, 1'b0); // coldest, no gas: safe
		send_fields(1'b0, 1'b1, TempHi, GasTop, 1'b0); // hottest, full gas: danger
		send_fields(1'b0, 1'b1, 360, 0, 1'b0);    // warm band: warning
		send_fields(1'b0, 1'b1, 365, 600, 1'b0);  // warning again: cadence restarts
		send_fields(1'b0, 1'b1, 370, 0, 1'b0);
		send_fields(1'b0, 1'b1, 370, 0, 1'b1);    // reset held: all lamps, silent
		send_fields(1'b0, 1'b1, 0, 400, 1'b0);    // gas in the gap: no band
		send_fields(1'b0, 1'b1, 1, 400, 1'b0);    // still compared to the older sample
		send_fields(1'b0, 1'b1, 0, 5, 1'b0);      // back to safe
		send_fields(1'b1, 1'b1, -1, GasTop, 1'b0); // gas danger, press still debounced
		send_fields(1'b0, 1'b0, 0, 0, 1'b0);

		// Raise the temperature limits above the fixed danger point.
		drain();
		lim                 = CfgReset;
		lim.temp_safe_limit = TempW'(500);
		lim.temp_warn_limit = TempW'(600);
		load_limits(lim);
		send_fields(1'b0, 1'b1, 450, 400, 1'b0);  // fixed danger temperature
		send_fields(1'b0, 1'b1, 400, 400, 1'b0);  // no band
		send_fields(1'b0, 1'b1, 420, 410, 1'b0);  // exactly at the fixed point

		// Random phases, each on its own threshold set; the receiver holds off
		// once at the start of each, and the sender drains before every load.
		for (int ph = 0; ph < RandomPhases; ph++) begin
			drain();
			case (ph)
				0: lim = CfgReset;
				1: lim = ordered_limits();
				2: lim = '{temp_safe_limit: TempW'(-400), temp_warn_limit: TempW'(-400),
					gas_normal_limit: '0, gas_warn_limit: '0, gas_danger_limit: '0,
					temp_change_min: '0, gas_change_min: '0, panic_debounce_ticks: '0};
				3: lim = '{temp_safe_limit: TempW'(800), temp_warn_limit: TempW'(800),
					gas_normal_limit: GasW'(GasTop), gas_warn_limit: GasW'(GasTop),
					gas_danger_limit: GasW'(GasTop), temp_change_min: 8'd255,
					gas_change_min: GasW'(GasTop), panic_debounce_ticks: 8'd255};
				default: lim = spread_limits();
			endcase
			load_limits(lim);
			sink_hold_req = 1'b1;
			run_phase((ph == 0) ? LongQuota : PhaseQuota, ph == 0);
		end

		drain();
		repeat (DrainCycles) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
